### hw/rtl/sample_frame_packetizer_macros.svh
// ---------------------------------------------------------------------------
// Sample frame packetizer assertion macros
// Shared concurrent assertion forms for the packetizer checkers.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_FRAME_PACKETIZER_MACROS_SVH
`define SAMPLE_FRAME_PACKETIZER_MACROS_SVH

// same-cycle implication
`define SFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample_frame_packetizer: assertion failed");

// next-cycle implication
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample_frame_packetizer: assertion failed");

`endif

### hw/rtl/sfp_pkg.sv
// ---------------------------------------------------------------------------
// Sample frame packetizer package
// Byte codes, register map and item types shared by the packetizer modules.
// ---------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [ByteW-1:0] SYNC_0 = 8'hDE;
  localparam logic [ByteW-1:0] SYNC_1 = 8'hAD;
  localparam logic [ByteW-1:0] SYNC_2 = 8'hBE;
  localparam logic [ByteW-1:0] SYNC_3 = 8'hEF;

  localparam logic [ByteW-1:0] ESC_CR = 8'h0D;
  localparam logic [ByteW-1:0] SUB_CR = 8'h0E;
  localparam logic [ByteW-1:0] ESC_LF = 8'h0A;
  localparam logic [ByteW-1:0] SUB_LF = 8'h0B;

  localparam logic [ByteW-1:0] SPF_RESET = 8'd150;

  // word index of each register
  localparam logic [AddrW-3:0] REG_SAMPLES_PER_FRAME = 1'b0;

  typedef enum logic [2:0] {
    POS_SYNC0 = 3'd0,
    POS_SYNC1 = 3'd1,
    POS_SYNC2 = 3'd2,
    POS_SYNC3 = 3'd3,
    POS_LO    = 3'd4,
    POS_HI    = 3'd5,
    POS_SUM   = 3'd6
  } seq_pos_e;

  typedef struct packed {
    logic [ByteW-1:0] lo;
    logic [ByteW-1:0] hi;
    logic             first;
    logic             ends;
    logic [ByteW-1:0] sum;
  } item_t;

endpackage

### hw/rtl/sfp_frame_ctl.sv
// ---------------------------------------------------------------------------
// Sample frame packetizer frame control
// Tracks the frame position and running checksum and forms one sample item.
// ---------------------------------------------------------------------------
module sfp_frame_ctl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [sfp_pkg::SampleW-1:0]  sample_value_i,
  input  logic [sfp_pkg::ByteW-1:0]    samples_per_frame_i,
  output sfp_pkg::item_t               item_o
);
  import sfp_pkg::*;

  logic [ByteW-1:0] sample_count_q, sample_count_d;
  logic [ByteW-1:0] running_sum_q, running_sum_d;
  logic [ByteW-1:0] lo_raw, lo, hi, sum_new;
  logic [ByteW:0]   count_next;
  logic             ends;

  assign lo_raw = sample_value_i[ByteW-1:0];
  assign hi     = {{(2*ByteW-SampleW){1'b0}}, sample_value_i[SampleW-1:ByteW]};

  always_comb begin
    priority if (lo_raw == ESC_CR) begin
      lo = SUB_CR;
    end else if (lo_raw == ESC_LF) begin
      lo = SUB_LF;
    end else begin
      lo = lo_raw;
    end
  end

  assign sum_new    = running_sum_q + lo + hi;
  assign count_next = {1'b0, sample_count_q} + {{ByteW{1'b0}}, 1'b1};
  assign ends       = count_next >= {1'b0, samples_per_frame_i};

  assign item_o.lo    = lo;
  assign item_o.hi    = hi;
  assign item_o.first = (sample_count_q == '0);
  assign item_o.ends  = ends;
  assign item_o.sum   = sum_new;

  always_comb begin
    sample_count_d = sample_count_q;
    running_sum_d  = running_sum_q;
    if (accept_i) begin
      if (ends) begin
        sample_count_d = '0;
        running_sum_d  = '0;
      end else begin
        sample_count_d = count_next[ByteW-1:0];
        running_sum_d  = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
      running_sum_q  <= '0;
    end else begin
      sample_count_q <= sample_count_d;
      running_sum_q  <= running_sum_d;
    end
  end

endmodule

### hw/rtl/sfp_byte_seq.sv
// ---------------------------------------------------------------------------
// Sample frame packetizer byte sequencer
// Holds one item and steps its bytes into the output register.
// ---------------------------------------------------------------------------
module sfp_byte_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  sfp_pkg::item_t             item_i,
  output logic                       busy_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [sfp_pkg::ByteW-1:0]  out_byte_o,
  output logic                       run_last_o,
  output logic                       frame_end_o
);
  import sfp_pkg::*;

  item_t            item_q;
  logic             item_valid_q, item_valid_d;
  seq_pos_e         pos_q, pos_d, last_pos;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, cur_byte;
  logic             run_last_q, frame_end_q;
  logic             out_load, item_done;

  assign last_pos  = item_q.ends ? POS_SUM : POS_HI;
  assign out_load  = item_valid_q && (!out_valid_q || !out_stall_i);
  assign item_done = out_load && (pos_q == last_pos);
  assign busy_o    = item_valid_q && !item_done;

  always_comb begin
    unique case (pos_q)
      POS_SYNC0: cur_byte = SYNC_0;
      POS_SYNC1: cur_byte = SYNC_1;
      POS_SYNC2: cur_byte = SYNC_2;
      POS_SYNC3: cur_byte = SYNC_3;
      POS_LO:    cur_byte = item_q.lo;
      POS_HI:    cur_byte = item_q.hi;
      POS_SUM:   cur_byte = item_q.sum;
      default:   cur_byte = item_q.sum;
    endcase
  end

  always_comb begin
    item_valid_d = item_valid_q;
    pos_d        = pos_q;
    if (load_i) begin
      item_valid_d = 1'b1;
      pos_d        = item_i.first ? POS_SYNC0 : POS_LO;
    end else if (item_done) begin
      item_valid_d = 1'b0;
    end else if (out_load) begin
      pos_d = seq_pos_e'(pos_q + 3'd1);
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      pos_q        <= POS_SYNC0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
    if (out_load) begin
      out_byte_q  <= cur_byte;
      run_last_q  <= (pos_q == last_pos);
      frame_end_q <= (pos_q == POS_SUM);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

### hw/rtl/sample_frame_packetizer.sv
// ---------------------------------------------------------------------------
// Sample frame packetizer
// Packs 10-bit samples into a byte stream of sync-framed, checksummed frames.
// ---------------------------------------------------------------------------
// Each sample item yields 2 to 7 bytes, one byte per cycle on the output
// port while out_stall_i is low: 4 sync bytes before the first sample of a
// frame, low and high byte, and the checksum after the last sample. The
// next sample is taken in the cycle that the last byte of the previous one
// moves into the output register. samples_per_frame lives at byte address 0
// of the configuration port and is to be written by the user only while the
// block is idle; the block itself does not enforce this.
module sample_frame_packetizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfp_pkg::AddrW-1:0]    paddr,
  input  logic [sfp_pkg::DataW-1:0]    pwdata,
  output logic [sfp_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sfp_pkg::SampleW-1:0]  sample_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sfp_pkg::ByteW-1:0]    out_byte_o,
  output logic                         run_last_o,
  output logic                         frame_end_o
);
  import sfp_pkg::*;

  logic [ByteW-1:0] spf_q, spf_d;
  logic             reg_sel, accept, busy;
  item_t            item;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1:2] == REG_SAMPLES_PER_FRAME);
  assign prdata  = reg_sel ? {{(DataW-ByteW){1'b0}}, spf_q} : '0;

  always_comb begin
    spf_d = spf_q;
    if (psel && penable && pwrite && reg_sel) begin
      spf_d = pwdata[ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spf_q <= SPF_RESET;
    end else begin
      spf_q <= spf_d;
    end
  end

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  sfp_frame_ctl u_frame_ctl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .sample_value_i      (sample_value_i),
    .samples_per_frame_i (spf_q),
    .item_o              (item)
  );

  sfp_byte_seq u_byte_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .item_i      (item),
    .busy_o      (busy),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule

### hw/rtl/sfp_checker.sv
// ---------------------------------------------------------------------------
// Sample frame packetizer checker
// Port-level assertions on the input handshake and the output byte stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "sample_frame_packetizer_macros.svh"

module sfp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [sfp_pkg::SampleW-1:0]  sample_value_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sfp_pkg::ByteW-1:0]    out_byte_o,
  input logic                         run_last_o,
  input logic                         frame_end_o
);

  `SFP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(sample_value_i))
  `SFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o))
  `SFP_ASSERT_IMP(a_sum_ends_run, clk_i, rst_ni, out_valid_o && frame_end_o, run_last_o)
  `SFP_ASSERT_NEXT(a_run_no_gap, clk_i, rst_ni, out_valid_o && !run_last_o, out_valid_o)

endmodule

bind sample_frame_packetizer sfp_checker u_sfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .sample_value_i (sample_value_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .run_last_o     (run_last_o),
  .frame_end_o    (frame_end_o)
);
